// ===== sv/sine_fade_envelope_defines.svh =====
// Assertion macros for the sine fade envelope.
`ifndef SINE_FADE_ENVELOPE_DEFINES_SVH
`define SINE_FADE_ENVELOPE_DEFINES_SVH
`ifndef SYNTHESIS
`define SFE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SFE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SFE_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/sfe_pkg.sv =====
// Shared types, constants and the quarter-sine gain function.
`default_nettype none
package sfe_pkg;

  localparam int POS_W       = 24;
  localparam int FRAME_W     = 32;
  localparam int CNT_W       = 5;
  localparam int GAIN_W      = 17;
  localparam int GAIN_FRAC   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int CC_W        = 4;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT,
    REG_FADE_IN,
    REG_FADE_OUT,
    REG_TOTAL
  } reg_idx_t;

  typedef struct packed {
    logic             in_en;
    logic [POS_W-1:0] in_pos;
    logic [POS_W-1:0] in_len;
    logic             out_en;
    logic [POS_W-1:0] out_pos;
    logic [POS_W-1:0] out_len;
  } fade_cmd_t;

  localparam int CMD_W = $bits(fade_cmd_t);

  function automatic logic [GAIN_W-1:0] sine_q16(input int unsigned idx,
                                                 input int unsigned phase_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (64'(idx) * HALF_PI_Q30) >> phase_bits;
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[GAIN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/sfe_queue.sv =====
// Short FIFO between the classifying front and the gain back end.
`default_nettype none
module sfe_queue
  import sfe_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_B = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_B-1:0] count;

  assign full     = (count == CNT_B'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfe_front.sv =====
// Front end: frame and channel counting, fade window classification.
`default_nettype none
module sfe_front
  import sfe_pkg::*;
#(
  parameter int SAMPLE_BITS  = 24,
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_fire,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic                          track_start,
  input  wire logic [CC_W-1:0]               channel_count,
  input  wire logic [POS_W-1:0]              fade_in_frames,
  input  wire logic [POS_W-1:0]              fade_out_frames,
  input  wire logic [FRAME_W-1:0]            total_frames,
  output logic [SAMPLE_BITS+CMD_W-1:0]       push_data
);

  localparam int CP_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [FRAME_W-1:0] frame_position;
  logic [CP_W-1:0]    channel_position;
  logic [FRAME_W-1:0] f;
  logic [CP_W-1:0]    cp;
  logic [POS_W-1:0]   nin;
  logic [POS_W-1:0]   nout;
  logic [FRAME_W-1:0] tf;
  logic [CNT_W-1:0]   chans;
  logic [CNT_W-1:0]   cp_inc;
  fade_cmd_t          cmd;

  always_comb begin
    f    = track_start ? '0 : frame_position;
    cp   = track_start ? '0 : channel_position;
    nin  = (FRAME_W'(fade_in_frames) < total_frames) ? fade_in_frames
                                                      : total_frames[POS_W-1:0];
    nout = (FRAME_W'(fade_out_frames) < total_frames) ? fade_out_frames
                                                       : total_frames[POS_W-1:0];
    tf   = total_frames - f;

    cmd.in_en   = (nin != '0) && (f < FRAME_W'(nin));
    cmd.in_pos  = f[POS_W-1:0];
    cmd.in_len  = nin;
    cmd.out_en  = (nout != '0) && (f < total_frames) && (tf <= FRAME_W'(nout));
    cmd.out_pos = tf[POS_W-1:0];
    cmd.out_len = nout;

    priority if (channel_count == '0) begin
      chans = CNT_W'(1);
    end else if (CNT_W'(channel_count) > CNT_W'(MAX_CHANNELS)) begin
      chans = CNT_W'(MAX_CHANNELS);
    end else begin
      chans = CNT_W'(channel_count);
    end
    cp_inc = CNT_W'(cp) + 1'b1;
  end

  assign push_data = {sample_in, cmd};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position   <= '0;
      channel_position <= '0;
    end else if (in_fire) begin
      if (cp_inc >= chans) begin
        channel_position <= '0;
        frame_position   <= (f == '1) ? f : f + 1'b1;
      end else begin
        channel_position <= cp_inc[CP_W-1:0];
        frame_position   <= f;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfe_back.sv =====
// Back end: shared restoring divider, quarter-sine ROM, multiply and round.
`default_nettype none
module sfe_back
  import sfe_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int PHASE_BITS  = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
  input  wire fade_cmd_t                     q_cmd,
  output logic                               q_pop,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      sample_out
);

  localparam int ROM_SIZE = (1 << PHASE_BITS) + 1;
  localparam int IDX_W    = PHASE_BITS + 1;
  localparam int BC_W     = $clog2(PHASE_BITS + 1);
  localparam int PROD_W   = SAMPLE_BITS + GAIN_W + 1;

  function automatic logic [ROM_SIZE-1:0][GAIN_W-1:0] build_rom();
    logic [ROM_SIZE-1:0][GAIN_W-1:0] rom;
    for (int i = 0; i < ROM_SIZE; i++) begin
      rom[i] = sine_q16(i, PHASE_BITS);
    end
    return rom;
  endfunction

  localparam logic [ROM_SIZE-1:0][GAIN_W-1:0] SINE_ROM = build_rom();

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_ROM,
    S_MUL,
    S_RND,
    S_FIN
  } state_t;

  state_t                         state;
  fade_cmd_t                      cmd;
  logic signed [SAMPLE_BITS-1:0]  acc;
  logic [POS_W:0]                 rem;
  logic [POS_W-1:0]               divisor;
  logic [IDX_W-1:0]               quot;
  logic [BC_W-1:0]                bit_cnt;
  logic [GAIN_W-1:0]              gain;
  logic signed [PROD_W-1:0]       prod;
  logic                           ge;
  logic [POS_W:0]                 rs;
  logic [PROD_W-1:0]              rnd;
  logic                           take_out;

  always_comb begin
    ge       = (rem >= {1'b0, divisor});
    rs       = ge ? rem - {1'b0, divisor} : rem;
    rnd      = prod + PROD_W'(1 << (GAIN_FRAC - 1));
    q_pop    = (state == S_IDLE) && q_valid;
    take_out = (state == S_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cmd       <= '0;
    end else begin
      if (take_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            acc   <= q_sample;
            cmd   <= q_cmd;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          quot    <= '0;
          bit_cnt <= BC_W'(PHASE_BITS);
          priority if (cmd.in_en) begin
            cmd.in_en <= 1'b0;
            rem       <= {1'b0, cmd.in_pos};
            divisor   <= cmd.in_len;
            state     <= S_DIV;
          end else if (cmd.out_en) begin
            cmd.out_en <= 1'b0;
            rem        <= {1'b0, cmd.out_pos};
            divisor    <= cmd.out_len;
            state      <= S_DIV;
          end else begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          rem  <= {rs[POS_W-1:0], 1'b0};
          quot <= {quot[IDX_W-2:0], ge};
          if (bit_cnt == '0) begin
            state <= S_ROM;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_ROM: begin
          gain  <= SINE_ROM[quot];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= acc * $signed({1'b0, gain});
          state <= S_RND;
        end
        S_RND: begin
          acc   <= rnd[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
          state <= S_SETUP;
        end
        S_FIN: begin
          if (take_out) begin
            sample_out <= acc;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/sine_fade_envelope.sv =====
// From an input transfer a sample passes through the queue; the back end then runs
// setup, divide, ROM, multiply and round for each active fade (at most two), and
// a finish state that waits until the output can be taken before the next sample.
// The back end works on one sample at a time; its shared restoring divider yields one quotient bit per cycle.
// A two-entry queue takes new samples while the back end works.
// Reset clears counters, queue and back end, and loads register defaults.
`default_nettype none
`include "sine_fade_envelope_defines.svh"
module sine_fade_envelope
  import sfe_pkg::*;
#(
  parameter int SAMPLE_BITS  = 24,
  parameter int PHASE_BITS   = 10,
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]                  prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic                          track_start,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample_out
);

  localparam int QW = SAMPLE_BITS + CMD_W;

  logic [CC_W-1:0]    channel_count;
  logic [POS_W-1:0]   fade_in_frames;
  logic [POS_W-1:0]   fade_out_frames;
  logic [FRAME_W-1:0] total_frames;
  logic               cfg_wr;
  reg_idx_t           reg_idx;
  logic               in_fire;
  logic [QW-1:0]      push_data;
  logic [QW-1:0]      q_data;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  fade_cmd_t          q_cmd;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = reg_idx_t'(paddr[3:2]);
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign q_cmd    = fade_cmd_t'(q_data[CMD_W-1:0]);
  assign q_sample = q_data[QW-1:CMD_W];

  always_comb begin
    unique case (reg_idx)
      REG_CHANNEL_COUNT: prdata = DATA_W'(channel_count);
      REG_FADE_IN:       prdata = DATA_W'(fade_in_frames);
      REG_FADE_OUT:      prdata = DATA_W'(fade_out_frames);
      REG_TOTAL:         prdata = DATA_W'(total_frames);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= CC_W'(2);
      fade_in_frames  <= '0;
      fade_out_frames <= '0;
      total_frames    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CHANNEL_COUNT: channel_count   <= pwdata[CC_W-1:0];
        REG_FADE_IN:       fade_in_frames  <= pwdata[POS_W-1:0];
        REG_FADE_OUT:      fade_out_frames <= pwdata[POS_W-1:0];
        REG_TOTAL:         total_frames    <= pwdata[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfe_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .sample_in       (sample_in),
    .track_start     (track_start),
    .channel_count   (channel_count),
    .fade_in_frames  (fade_in_frames),
    .fade_out_frames (fade_out_frames),
    .total_frames    (total_frames),
    .push_data       (push_data)
  );

  sfe_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  sfe_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!q_empty),
    .q_sample   (q_sample),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .sample_out (sample_out)
  );

  `SFE_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, !q_empty, "pop from empty queue")
  `SFE_ASSERT_NXT(a_push_lands, clk, rst, in_fire && !q_pop, !q_empty, "transfer lost")
  `SFE_ASSERT_NXT(a_one_at_a_time, clk, rst, q_pop, !q_pop, "back end took two items")

endmodule
`default_nettype wire
